// File: sv/lda_gibbs_token_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// lda gibbs token sampler assertion macros
// property wrappers used by the asserting unit
// ----------------------------------------------------------------------------
`ifndef LDA_GIBBS_TOKEN_SAMPLER_UNIT_MACROS_SVH
`define LDA_GIBBS_TOKEN_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define LGTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lgts: same-cycle check failed");

// next-cycle implication
`define LGTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lgts: next-cycle check failed");

`endif

// File: sv/lgts_pkg.sv
// ----------------------------------------------------------------------------
// lgts_pkg
// shared sizes, codes and types of the lda gibbs token sampler
// ----------------------------------------------------------------------------
package lgts_pkg;

    localparam int MAX_TOPICS = 64;
    localparam int TOPIC_W    = 6;
    localparam int K_W        = 7;
    localparam int WORD_W     = 12;
    localparam int DOC_W      = 10;

    localparam int WT_W  = 24;
    localparam int DT_W  = 16;
    localparam int TT_W  = 32;
    localparam int WT_AW = WORD_W + TOPIC_W;
    localparam int DT_AW = DOC_W + TOPIC_W;

    localparam int NUM_W  = 41;
    localparam int DEN_W  = 49;
    localparam int Q_W    = 32;
    localparam int DA_W   = 33;
    localparam int PROD_W = 65;
    localparam int WGT_W  = 49;
    localparam int ACC_W  = 56;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_UNDER = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    localparam logic REQ_ADD      = 1'b0;
    localparam logic REQ_RESAMPLE = 1'b1;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_TOPICS = 2'd0;
    localparam t_reg_idx REG_ALPHA  = 2'd1;
    localparam t_reg_idx REG_BETA   = 2'd2;
    localparam t_reg_idx REG_VBETA  = 2'd3;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [WORD_W-1:0] word;
        logic [DOC_W-1:0]  doc;
        logic [TOPIC_W-1:0] topic;
    } t_cnt_cmd;

endpackage

// File: sv/lgts_div.sv
// ----------------------------------------------------------------------------
// lgts_div
// restoring divider, one quotient bit a cycle, saturating q16.16 ratio
// ----------------------------------------------------------------------------
module lgts_div import lgts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quot,
    output logic             o_done
);

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN} t_dstate;

    t_dstate          r_state;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_sh;
    logic [4:0]       r_cnt;

    logic [DEN_W:0]   n_rem2;
    logic             n_ge;
    logic [DEN_W:0]   n_diff;

    assign n_rem2 = {r_rem, r_sh[Q_W-1]};
    assign n_ge   = n_rem2 >= {1'b0, r_den};
    assign n_diff = n_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_den   <= i_den;
                        r_state <= D_CHK;
                    end
                end
                D_CHK: begin
                    if ({24'b0, r_num} >= {r_den, 16'b0}) begin
                        o_quot  <= '1;
                        o_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_rem   <= DEN_W'(r_num[NUM_W-1:16]);
                        r_sh    <= {r_num[15:0], 16'b0};
                        r_cnt   <= '0;
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem  <= n_ge ? n_diff[DEN_W-1:0] : n_rem2[DEN_W-1:0];
                    r_sh   <= {r_sh[Q_W-2:0], 1'b0};
                    o_quot <= {o_quot[Q_W-2:0], n_ge};
                    r_cnt  <= r_cnt + 5'd1;
                    if (&r_cnt) begin
                        o_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

endmodule

// File: sv/lgts_counts.sv
// ----------------------------------------------------------------------------
// lgts_counts
// word-topic, doc-topic and topic-total count memories with clearing sweep
// ----------------------------------------------------------------------------
module lgts_counts import lgts_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cnt_cmd        i_cmd,
    input  logic [WT_W-1:0] i_wt_wdata,
    input  logic [DT_W-1:0] i_dt_wdata,
    input  logic [TT_W-1:0] i_tt_wdata,
    output logic [WT_W-1:0] o_wt,
    output logic [DT_W-1:0] o_dt,
    output logic [TT_W-1:0] o_tt,
    output logic            o_ready
);

    logic [WT_W-1:0] wt_mem [0:(1 << WT_AW)-1];
    logic [DT_W-1:0] dt_mem [0:(1 << DT_AW)-1];
    logic [TT_W-1:0] tt_mem [0:MAX_TOPICS-1];

    logic             r_clearing;
    logic [WT_AW-1:0] r_clr_addr;

    logic [WT_AW-1:0] wt_addr;
    logic [DT_AW-1:0] dt_addr;

    assign wt_addr = {i_cmd.word, i_cmd.topic};
    assign dt_addr = {i_cmd.doc, i_cmd.topic};
    assign o_ready = !r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            wt_mem[r_clr_addr]                <= '0;
            dt_mem[r_clr_addr[DT_AW-1:0]]     <= '0;
            tt_mem[r_clr_addr[TOPIC_W-1:0]]   <= '0;
        end else if (i_cmd.wr) begin
            wt_mem[wt_addr]      <= i_wt_wdata;
            dt_mem[dt_addr]      <= i_dt_wdata;
            tt_mem[i_cmd.topic]  <= i_tt_wdata;
        end
        if (i_cmd.rd) begin
            o_wt <= wt_mem[wt_addr];
            o_dt <= dt_mem[dt_addr];
            o_tt <= tt_mem[i_cmd.topic];
        end
    end

endmodule

// File: sv/lda_gibbs_token_sampler_unit.sv
// ----------------------------------------------------------------------------
// lda_gibbs_token_sampler_unit
// collapsed gibbs sampling step per token, q16.16 weights, shared divider
// ----------------------------------------------------------------------------
// channel   | signals                                        | handshake
// item in   | i_req_type i_doc_index i_word_id i_old_topic   | start & !busy
//           | i_random_fraction                              |
// result    | o_new_topic o_status                           | o_done, one cycle
// config    | psel penable pwrite paddr pwdata prdata pready | apb, pready high
//
// add item: old topic's counts read and incremented; out-of-range topic:
// result the cycle after start; resample item: old topic's counts
// decremented, then per topic a weight via the 32-step divider (ending early
// when the ratio saturates), then a search over the stored sums
// after reset the count memories are swept, busy meanwhile
// results cannot be stalled
// ----------------------------------------------------------------------------
`include "lda_gibbs_token_sampler_unit_macros.svh"

module lda_gibbs_token_sampler_unit import lgts_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_req_type,
    input  logic [DOC_W-1:0]   i_doc_index,
    input  logic [WORD_W-1:0]  i_word_id,
    input  logic [TOPIC_W-1:0] i_old_topic,
    input  logic [31:0]        i_random_fraction,
    output logic               o_done,
    output logic [TOPIC_W-1:0] o_new_topic,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_OLD_RD, S_OLD_UPD, S_W_RD, S_W_LD, S_DIV, S_MUL,
        S_ACC, S_THR_LO, S_THR_HI, S_THR_SUM, S_SRCH_RD, S_SRCH, S_NEW_RD, S_NEW_UPD
    } t_state;

    t_state r_state;

    logic [K_W-1:0] r_topics;
    logic [31:0]    r_alpha;
    logic [31:0]    r_beta;
    logic [31:0]    r_vbeta;

    logic               r_req;
    logic [DOC_W-1:0]   r_doc;
    logic [WORD_W-1:0]  r_word;
    logic [TOPIC_W-1:0] r_old;
    logic [31:0]        r_rand;
    logic [TOPIC_W-1:0] r_t;
    t_status            r_stat;
    logic [DA_W-1:0]    r_da;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   r_acc;
    logic [ACC_W-1:0]   r_thr;
    logic [ACC_W-1:0]   r_rs_q;

    logic [ACC_W-1:0] rs_mem [0:MAX_TOPICS-1];

    logic [K_W-1:0]     k_act;
    logic               last_t;
    logic               wen;
    t_cnt_cmd           cmd;
    logic               up;
    logic               under;
    logic [WT_W-1:0]    wt_q;
    logic [DT_W-1:0]    dt_q;
    logic [TT_W-1:0]    tt_q;
    logic [WT_W-1:0]    wt_w;
    logic [DT_W-1:0]    dt_w;
    logic [TT_W-1:0]    tt_w;
    logic               cnt_ready;
    logic [NUM_W-1:0]   num;
    logic [DEN_W-1:0]   den_raw;
    logic [DEN_W-1:0]   den;
    logic [DA_W-1:0]    da;
    logic               div_done;
    logic [Q_W-1:0]     div_q;
    logic [Q_W-1:0]     mul_a;
    logic [DA_W-1:0]    mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [ACC_W-1:0]   acc_n;
    logic [TOPIC_W-1:0] rs_raddr;

    // configuration
    assign pready = 1'b1;
    assign wen    = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_topics <= K_W'(MAX_TOPICS);
            r_alpha  <= 32'd51200;
            r_beta   <= 32'd6554;
            r_vbeta  <= 32'd26843546;
        end else if (wen) begin
            case (paddr[3:2])
                REG_TOPICS: r_topics <= pwdata[K_W-1:0];
                REG_ALPHA:  r_alpha  <= pwdata;
                REG_BETA:   r_beta   <= pwdata;
                REG_VBETA:  r_vbeta  <= pwdata;
                default:    r_alpha  <= r_alpha;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TOPICS: prdata = 32'(r_topics);
            REG_ALPHA:  prdata = r_alpha;
            REG_BETA:   prdata = r_beta;
            REG_VBETA:  prdata = r_vbeta;
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        if (r_topics == '0) begin
            k_act = K_W'(1);
        end else if (r_topics > K_W'(MAX_TOPICS)) begin
            k_act = K_W'(MAX_TOPICS);
        end else begin
            k_act = r_topics;
        end
    end

    assign last_t = (K_W'(r_t) == (k_act - K_W'(1)));
    assign busy   = (r_state != S_IDLE);

    // count memories
    assign cmd.rd    = (r_state == S_OLD_RD) || (r_state == S_W_RD) || (r_state == S_NEW_RD);
    assign cmd.wr    = (r_state == S_OLD_UPD) || (r_state == S_NEW_UPD);
    assign cmd.word  = r_word;
    assign cmd.doc   = r_doc;
    assign cmd.topic = (r_state == S_OLD_RD || r_state == S_OLD_UPD) ? r_old : r_t;

    assign up    = !((r_state == S_OLD_UPD) && (r_req == REQ_RESAMPLE));
    assign under = (wt_q == '0) || (dt_q == '0) || (tt_q == '0);

    always_comb begin
        if (up) begin
            wt_w = (&wt_q) ? wt_q : wt_q + 1'b1;
            dt_w = (&dt_q) ? dt_q : dt_q + 1'b1;
            tt_w = (&tt_q) ? tt_q : tt_q + 1'b1;
        end else begin
            wt_w = (wt_q == '0) ? wt_q : wt_q - 1'b1;
            dt_w = (dt_q == '0) ? dt_q : dt_q - 1'b1;
            tt_w = (tt_q == '0) ? tt_q : tt_q - 1'b1;
        end
    end

    lgts_counts u_counts (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_wt_wdata (wt_w),
        .i_dt_wdata (dt_w),
        .i_tt_wdata (tt_w),
        .o_wt       (wt_q),
        .o_dt       (dt_q),
        .o_tt       (tt_q),
        .o_ready    (cnt_ready)
    );

    // weight terms
    assign num     = NUM_W'({wt_q, 16'b0}) + NUM_W'(r_beta);
    assign den_raw = DEN_W'({tt_q, 16'b0}) + DEN_W'(r_vbeta);
    assign den     = (den_raw == '0) ? DEN_W'(1) : den_raw;
    assign da      = DA_W'({dt_q, 16'b0}) + DA_W'(r_alpha);

    lgts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_W_LD),
        .i_num   (num),
        .i_den   (den),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    // shared multiplier
    always_comb begin
        case (r_state)
            S_THR_LO: begin
                mul_a = r_acc[31:0];
                mul_b = DA_W'(r_rand);
            end
            S_THR_HI: begin
                mul_a = Q_W'(r_acc[ACC_W-1:32]);
                mul_b = DA_W'(r_rand);
            end
            default: begin
                mul_a = div_q;
                mul_b = r_da;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign acc_n = r_acc + ACC_W'(r_prod[PROD_W-1:16]);

    // running sums
    assign rs_raddr = (r_state == S_SRCH) ? r_t + 1'b1 : r_t;

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC) begin
            rs_mem[r_t] <= acc_n;
        end
        r_rs_q <= rs_mem[rs_raddr];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    if (cnt_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_req  <= i_req_type;
                        r_doc  <= i_doc_index;
                        r_word <= i_word_id;
                        r_old  <= i_old_topic;
                        r_rand <= i_random_fraction;
                        if (K_W'(i_old_topic) >= k_act) begin
                            o_done      <= 1'b1;
                            o_new_topic <= i_old_topic;
                            o_status    <= ST_RANGE;
                        end else begin
                            r_state <= S_OLD_RD;
                        end
                    end
                end
                S_OLD_RD: r_state <= S_OLD_UPD;
                S_OLD_UPD: begin
                    if (r_req == REQ_RESAMPLE) begin
                        r_stat  <= under ? ST_UNDER : ST_OK;
                        r_t     <= '0;
                        r_acc   <= '0;
                        r_state <= S_W_RD;
                    end else begin
                        o_done      <= 1'b1;
                        o_new_topic <= r_old;
                        o_status    <= ST_OK;
                        r_state     <= S_IDLE;
                    end
                end
                S_W_RD: r_state <= S_W_LD;
                S_W_LD: begin
                    r_da    <= da;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= acc_n;
                    if (last_t) begin
                        r_state <= S_THR_LO;
                    end else begin
                        r_t     <= r_t + 1'b1;
                        r_state <= S_W_RD;
                    end
                end
                S_THR_LO: r_state <= S_THR_HI;
                S_THR_HI: begin
                    r_thr   <= ACC_W'(r_prod[63:32]);
                    r_state <= S_THR_SUM;
                end
                S_THR_SUM: begin
                    r_thr   <= r_thr + r_prod[ACC_W-1:0];
                    r_t     <= '0;
                    r_state <= S_SRCH_RD;
                end
                S_SRCH_RD: r_state <= S_SRCH;
                S_SRCH: begin
                    if ((r_rs_q > r_thr) || last_t) begin
                        r_state <= S_NEW_RD;
                    end else begin
                        r_t <= r_t + 1'b1;
                    end
                end
                S_NEW_RD: r_state <= S_NEW_UPD;
                S_NEW_UPD: begin
                    o_done      <= 1'b1;
                    o_new_topic <= r_t;
                    o_status    <= r_stat;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `LGTS_ASSERT_NOW(a_done_when_idle, o_done, !busy)
    `LGTS_ASSERT_NEXT(a_accept_goes_busy, start && !busy && (K_W'(i_old_topic) < k_act), busy)
    `LGTS_ASSERT_NOW(a_topic_in_range, o_done && (o_status != ST_RANGE), K_W'(o_new_topic) < k_act)

endmodule
